@@ rtl/sffe_pkg.sv @@
// Package for the single-frequency filtering envelope block.
// Sine table function, field widths and register indexes. No dependencies.
`default_nettype none
package sffe_pkg;
    localparam int unsigned PhaseBitsDefault = 24;
    localparam int unsigned SineBitsDefault  = 10;
    localparam int unsigned StepW   = 24;
    localparam int unsigned RadiusW = 15;
    localparam int unsigned CfgW    = 24;
    localparam logic [StepW-1:0]   StepReset   = 24'd3355443;
    localparam logic [RadiusW-1:0] RadiusReset = 15'd31785;
    localparam logic CfgIdxStep   = 1'b0;
    localparam logic CfgIdxRadius = 1'b1;

    typedef struct packed {
        logic signed [16:0] diff;
        logic               start;
        logic [13:0]        idx;
    } t_cmd;

    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569305;
    localparam logic [63:0] C7 = 64'd5026994;
    localparam logic [63:0] C9 = 64'd172272;

    // Q30 quarter-wave polynomial, entry k of 2^(tb-2) per quarter turn.
    // Only used to fill constant tables at elaboration.
    function automatic logic [15:0] quarter_sine(input int unsigned k,
                                                 input int unsigned tb);
        logic [63:0] x, x2, p, s;
        x = 64'(k) << (32 - tb);
        x2 = (x * x) >> 30;
        p = C7 - ((x2 * C9) >> 30);
        p = C5 - ((x2 * p) >> 30);
        p = C3 - ((x2 * p) >> 30);
        p = C1 - ((x2 * p) >> 30);
        s = (x * p) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) s = 64'd32767;
        return 16'(s);
    endfunction
endpackage
`default_nettype wire

@@ rtl/sffe_front.sv @@
// Front end: sample difference and phase accumulation, emits commands.
// Depends on sffe_pkg.
`default_nettype none
module sffe_front #(
    parameter int unsigned PHASE_BITS      = sffe_pkg::PhaseBitsDefault,
    parameter int unsigned SINE_TABLE_BITS = sffe_pkg::SineBitsDefault
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [15:0]         i_sample,
    input  wire logic                       i_start,
    input  wire logic [sffe_pkg::StepW-1:0] i_step,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output sffe_pkg::t_cmd                  o_cmd
);
    logic signed [15:0]    r_prev;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] w_step;
    logic                  w_go;

    generate
        if (PHASE_BITS >= 24) begin : g_shl
            assign w_step = PHASE_BITS'(i_step) << (PHASE_BITS - 24);
        end else begin : g_shr
            assign w_step = PHASE_BITS'(i_step >> (24 - PHASE_BITS));
        end
    endgenerate

    assign o_ready = i_ready;
    assign o_valid = i_valid;
    assign w_go    = i_valid && i_ready;

    always_comb begin
        o_cmd.start = i_start;
        o_cmd.diff  = 17'(i_sample) - 17'(r_prev);
        if (PHASE_BITS >= SINE_TABLE_BITS)
            o_cmd.idx = 14'(r_phase >> (PHASE_BITS - SINE_TABLE_BITS));
        else
            o_cmd.idx = 14'({14'd0, r_phase} << (SINE_TABLE_BITS - PHASE_BITS));
        o_cmd.idx = o_cmd.idx & 14'((32'd1 << SINE_TABLE_BITS) - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_phase <= '0;
        end else if (w_go) begin
            r_prev  <= i_sample;
            r_phase <= i_start ? w_step : r_phase + w_step;
        end
    end
endmodule
`default_nettype wire

@@ rtl/sffe_queue.sv @@
// Two-entry command queue between front and back ends.
// Depends on sffe_pkg.
`default_nettype none
module sffe_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  sffe_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  wire logic       i_ready,
    output sffe_pkg::t_cmd  o_cmd
);
    sffe_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/sffe_back.sv @@
// Back end: sine lookup, mix, complex one-pole filter, iterative square root.
// Depends on sffe_pkg.
`default_nettype none
module sffe_back #(
    parameter int unsigned SINE_TABLE_BITS = sffe_pkg::SineBitsDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  sffe_pkg::t_cmd                    i_cmd,
    input  wire logic [sffe_pkg::RadiusW-1:0] i_radius,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [71:0]                       o_data
);
    localparam int unsigned TSize = 1 << SINE_TABLE_BITS;
    localparam int unsigned QBits = SINE_TABLE_BITS - 2;
    localparam int unsigned QSize = 1 << QBits;
    typedef enum logic [2:0] {S_IDLE, S_MIX, S_POLE, S_SUM, S_SQRT, S_OUT} t_state;

    // quarter-wave table, entries 0..QSize inclusive
    function automatic logic [(QSize+1)*16-1:0] build_qrom();
        logic [(QSize+1)*16-1:0] t;
        t = '0;
        for (int k = 0; k <= QSize; k++)
            t[k*16 +: 16] = sffe_pkg::quarter_sine(k, SINE_TABLE_BITS);
        return t;
    endfunction

    localparam logic [(QSize+1)*16-1:0] QRom = build_qrom();

    function automatic logic signed [16:0] sine_at(input logic [13:0] idx);
        logic [1:0]       quad;
        logic [QBits-1:0] w;
        logic [QBits:0]   k;
        logic signed [16:0] v;
        quad = 2'(idx >> QBits);
        w = idx[QBits-1:0];
        k = quad[0] ? (QBits+1)'(QSize) - {1'b0, w} : {1'b0, w};
        v = $signed({1'b0, QRom[32'(k)*16 +: 16]});
        return quad[1] ? -v : v;
    endfunction

    t_state r_state;
    logic signed [16:0] r_diff, r_sin, r_cos;
    logic signed [39:0] r_yre, r_yim;
    logic signed [33:0] r_mre, r_mim;
    logic signed [55:0] r_pre, r_pim;
    logic signed [31:0] r_a, r_b;
    logic [63:0] r_n, r_res, r_bit;
    logic [5:0]  r_cnt;
    logic [71:0] r_out;
    logic [13:0] w_cidx;
    logic signed [41:0] w_nre, w_nim;
    logic signed [39:0] w_yre, w_yim;
    logic [63:0] w_sq;
    logic signed [63:0] w_sqa, w_sqb;
    logic [63:0] w_root;

    function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
        if (v > 42'sh7F_FFFF_FFFF) return 40'sh7F_FFFF_FFFF;
        if (v < -42'sh80_0000_0000) return -40'sh80_0000_0000;
        return 40'(v);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [39:0] v);
        logic signed [24:0] t;
        t = 25'(v >>> 15);
        if (t > 25'sh7F_FFFF) return 24'h7F_FFFF;
        if (t < -25'sh80_0000) return 24'h80_0000;
        return 24'(t);
    endfunction

    assign w_cidx = 14'((32'(i_cmd.idx) + TSize / 4) & (TSize - 1));
    assign w_nre  = 42'(r_mre) - 42'((r_pre + 56'sd16384) >>> 15);
    assign w_nim  = 42'(r_mim) - 42'((r_pim + 56'sd16384) >>> 15);
    assign w_yre  = sat40(w_nre);
    assign w_yim  = sat40(w_nim);
    assign w_sq   = r_res + r_bit;
    assign w_sqa  = r_a * r_a;
    assign w_sqb  = r_b * r_b;
    assign w_root = (r_n >= w_sq) ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_yre <= '0; r_yim <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_diff <= i_cmd.diff;
                    r_sin  <= sine_at(i_cmd.idx);
                    r_cos  <= sine_at(w_cidx);
                    if (i_cmd.start) begin
                        r_yre <= '0; r_yim <= '0;
                        r_out <= '0;
                        r_state <= S_OUT;
                    end else r_state <= S_MIX;
                end
                S_MIX: begin
                    r_mre <= r_diff * r_cos;
                    r_mim <= r_diff * r_sin;
                    r_pre <= $signed({1'b0, i_radius}) * r_yre;
                    r_pim <= $signed({1'b0, i_radius}) * r_yim;
                    r_state <= S_POLE;
                end
                S_POLE: begin
                    r_yre <= w_yre; r_yim <= w_yim;
                    r_a <= 32'(w_yre >>> 8); r_b <= 32'(w_yim >>> 8);
                    r_out[71:48] <= sat24(w_yim);
                    r_out[47:24] <= sat24(w_yre);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_n <= $unsigned(w_sqa) + $unsigned(w_sqb);
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                    r_cnt <= 6'd32;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_n >= w_sq) begin
                        r_n   <= r_n - w_sq;
                        r_res <= (r_res >> 1) + r_bit;
                    end else r_res <= r_res >> 1;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_SQRT && r_cnt == 6'd1) begin
                r_out[23:0] <= (w_root[63:7] > 57'hFF_FFFF) ? 24'hFF_FFFF : w_root[30:7];
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/single_frequency_filter_envelope.sv @@
// Single-frequency filtering envelope. The back end takes a new beat only once
// it has sent the last, bound by the 32-step square root. Start beats skip the
// filter and give a zero result. Synchronous active-low reset clears control,
// phase and filter state and restores register defaults. Two-entry queue decouples front and back.
`default_nettype none
module single_frequency_filter_envelope #(
    parameter int unsigned PHASE_BITS      = sffe_pkg::PhaseBitsDefault,
    parameter int unsigned SINE_TABLE_BITS = sffe_pkg::SineBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // sample
    input  wire logic        s_axis_tuser,  // start_of_signal
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // envelope, filter_real, filter_imag
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [sffe_pkg::CfgW-1:0] i_cfg_data
);
    logic [sffe_pkg::StepW-1:0]   r_step;
    logic [sffe_pkg::RadiusW-1:0] r_radius;
    logic f_valid, f_ready, b_valid, b_ready;
    sffe_pkg::t_cmd f_cmd, b_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= sffe_pkg::StepReset;
            r_radius <= sffe_pkg::RadiusReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sffe_pkg::CfgIdxStep:   r_step   <= i_cfg_data;
                sffe_pkg::CfgIdxRadius: r_radius <= i_cfg_data[sffe_pkg::RadiusW-1:0];
                default: ;
            endcase
        end
    end

    sffe_front #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata), .i_start(s_axis_tuser), .i_step(r_step),
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd));

    sffe_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(b_valid), .i_ready(b_ready), .o_cmd(b_cmd));

    sffe_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(b_valid), .o_ready(b_ready), .i_cmd(b_cmd),
        .i_radius(r_radius), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata));

`ifndef SYNTHESIS
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && b_ready && b_cmd.start) |=> ##1 (m_axis_tdata == '0))
        else $error("start beat result not zero");
    a_back_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_valid && b_ready) |=> !b_ready)
        else $error("back end took two commands");
`endif
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Testbench for single_frequency_filter_envelope: streams audio samples, predicts
// envelope and filter outputs with a local fixed-point model and checks every beat.
// Depends on sffe_pkg (register indexes, widths) and the RTL top level.
`default_nettype none
module tb;
    typedef struct packed {
        logic [23:0] fim;
        logic [23:0] fre;
        logic [23:0] env;
    } t_env_beat;

    typedef struct {
        logic signed [15:0] smp;
        logic               sos;
        logic               chk;
        t_env_beat          exp_beat;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = sffe_pkg::CfgIdxStep;
    logic [sffe_pkg::CfgW-1:0] i_cfg_data = '0;

    single_frequency_filter_envelope dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [23:0] step_reg;
    logic [14:0] radius_reg;
    logic signed [15:0] prev_smp;
    logic [23:0] phase_acc;
    logic signed [39:0] acc_re, acc_im;
    logic signed [17:0] sine_rom [0:1023];

    t_env_beat env_q [$];
    int fails = 0;
    int snd_idle = 15, rcv_idle = 52;

    function automatic logic signed [17:0] quarter_wave(input logic [9:0] ix);
        logic [63:0] x, x2, p, s;
        logic [1:0] qd;
        qd = ix[9:8];
        x = 64'(ix[7:0]) << 22;
        if (qd[0]) x = (64'd1 << 30) - x;
        x2 = (x * x) >> 30;
        p = 64'd5026994 - ((x2 * 64'd172272) >> 30);
        p = 64'd85569305 - ((x2 * p) >> 30);
        p = 64'd693598668 - ((x2 * p) >> 30);
        p = 64'd1686629713 - ((x2 * p) >> 30);
        s = (x * p) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767) s = 64'd32767;
        return qd[1] ? -18'(s) : 18'(s);
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint usqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_env_beat predict_envelope(input logic signed [15:0] smp,
                                                   input logic sos);
        t_env_beat o;
        longint d, c, sn, pr, pi, a, b, m;
        logic [9:0] ix;
        o = '0;
        if (sos) begin
            prev_smp = smp;
            phase_acc = step_reg;
            acc_re = '0;
            acc_im = '0;
            return o;
        end
        d = longint'(smp) - longint'(prev_smp);
        prev_smp = smp;
        ix = phase_acc[23:14];
        sn = sine_rom[ix];
        c = sine_rom[10'(ix + 10'd256)];
        phase_acc = phase_acc + step_reg;
        pr = (longint'(radius_reg) * longint'(acc_re) + 16384) >>> 15;
        pi = (longint'(radius_reg) * longint'(acc_im) + 16384) >>> 15;
        acc_re = 40'(sat(d * c - pr, -(64'sd1 << 39), (64'sd1 << 39) - 1));
        acc_im = 40'(sat(d * sn - pi, -(64'sd1 << 39), (64'sd1 << 39) - 1));
        a = longint'(acc_re) >>> 8;
        b = longint'(acc_im) >>> 8;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        m = usqrt(a * a + b * b) >>> 7;
        o.env = 24'(sat(m, 0, 16777215));
        o.fre = 24'(sat(longint'(acc_re) >>> 15, -8388608, 8388607));
        o.fim = 24'(sat(longint'(acc_im) >>> 15, -8388608, 8388607));
        return o;
    endfunction

    task automatic cfg_write(input logic ix, input logic [sffe_pkg::CfgW-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ix;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (ix == sffe_pkg::CfgIdxStep) step_reg = v;
        else radius_reg = v[14:0];
        @(posedge i_clk);
    endtask

    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        while (env_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] smp, input logic sos,
                               input logic chk, input t_env_beat fixed);
        t_env_beat e;
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tuser <= sos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        e = predict_envelope(smp, sos);
        if (chk && e != fixed)
            $display("%0t table row mismatch: expected %h actual-predicted %h",
                     $time, fixed, e);
        if (chk && e != fixed) fails++;
        env_q.insert(env_q.size(), e);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (env_q.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h", $time, m_axis_tdata);
                fails++;
            end else begin
                if (m_axis_tdata != env_q[0]) begin
                    $display("%0t mismatch: expected env=%h re=%h im=%h actual env=%h re=%h im=%h",
                             $time, env_q[0].env, env_q[0].fre, env_q[0].fim,
                             m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48]);
                    fails++;
                end
                void'(env_q.pop_front());
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    t_stim_row table_rows [$];

    task automatic add_row(input logic signed [15:0] s, input logic u, input logic k);
        t_stim_row r;
        r.smp = s;
        r.sos = u;
        r.chk = k;
        r.exp_beat = '0;
        table_rows.insert(table_rows.size(), r);
    endtask

    task automatic rand_signal(input int n);
        int shape;
        logic signed [15:0] s;
        shape = $urandom_range(3);
        for (int k = 0; k < n; k++) begin
            case (shape)
                0: s = 16'($urandom);
                1: s = (k % 2) ? 16'sh7fff : 16'sh8000;
                2: s = $signed(16'($urandom_range(200))) - 16'sd100;
                default: s = (k % 8 < 4) ? 16'sd20000 : -16'sd20000;
            endcase
            send_sample(s, k == 0 && $urandom_range(9) != 0, 1'b0, '0);
        end
    endtask

    initial begin
        for (int k = 0; k < 1024; k++) sine_rom[k] = quarter_wave(10'(k));
        step_reg = sffe_pkg::StepReset;
        radius_reg = sffe_pkg::RadiusReset;
        prev_smp = '0;
        phase_acc = '0;
        acc_re = '0;
        acc_im = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no start after reset, extremes, start beats (zero result)
        add_row(16'sh7fff, 1'b0, 1'b0);
        add_row(16'sh8000, 1'b0, 1'b0);
        add_row(16'sh8000, 1'b1, 1'b1);
        add_row(16'sh7fff, 1'b0, 1'b0);
        add_row(16'sh8000, 1'b0, 1'b0);
        add_row(16'sh7fff, 1'b0, 1'b0);
        add_row(16'sh0000, 1'b0, 1'b0);
        add_row(16'sh7fff, 1'b1, 1'b1);
        add_row(16'sh0001, 1'b0, 1'b0);
        add_row(-16'sd1, 1'b0, 1'b0);
        add_row(16'sh0000, 1'b1, 1'b1);
        add_row(16'sh0000, 1'b0, 1'b0);
        foreach (table_rows[k])
            send_sample(table_rows[k].smp, table_rows[k].sos, table_rows[k].chk,
                        table_rows[k].exp_beat);
        drain_idle();

        // saturation: full radius, zero step, alternating extremes grow the filter
        cfg_write(sffe_pkg::CfgIdxRadius, 24'h007fff);
        cfg_write(sffe_pkg::CfgIdxStep, 24'h000000);
        for (int k = 0; k < 300; k++)
            send_sample(k % 2 ? 16'sh8000 : 16'sh7fff, k == 0, 1'b0, '0);
        drain_idle();
        cfg_write(sffe_pkg::CfgIdxStep, 24'hffffff);
        cfg_write(sffe_pkg::CfgIdxRadius, 24'h000000);
        rand_signal(10);
        drain_idle();

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = ph == 0 ? 15 : (ph == 1 ? 52 : 0);
            rcv_idle = ph == 0 ? 52 : (ph == 1 ? 15 : 0);
            for (int g = 0; g < 3; g++) begin
                cfg_write(sffe_pkg::CfgIdxStep,
                          $urandom_range(3) == 0 ? 24'h000000 : 24'($urandom));
                cfg_write(sffe_pkg::CfgIdxRadius,
                          $urandom_range(3) == 0 ? 24'h007fff
                                                 : 24'($urandom_range(32767)));
                for (int k = 0; k < 4; k++) rand_signal($urandom_range(60, 1));
                drain_idle();
            end
        end

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ single_frequency_filter_envelope.f @@
rtl/sffe_pkg.sv
rtl/sffe_front.sv
rtl/sffe_queue.sv
rtl/sffe_back.sv
rtl/single_frequency_filter_envelope.sv
test/tb.sv
